/* rtl/core/ssrs_pkg.sv */
// ============================================================================
// ssrs_pkg
// shared types, codes and tables for the seven-segment raster scroller
// ============================================================================
`default_nettype none

package ssrs_pkg;

    // stream and configuration port widths
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;

    // request field widths and positions in tdata
    localparam int ACT_W   = 3;
    localparam int AMT_W   = 16;
    localparam int COORD_W = 8;
    localparam int ACT_LSB = 0;
    localparam int AMT_LSB = ACT_LSB + ACT_W;
    localparam int ROW_LSB = AMT_LSB + AMT_W;
    localparam int COL_LSB = ROW_LSB + COORD_W;

    localparam int STAT_W  = 2;
    localparam int SEG_W   = 8;
    localparam int THIRD_W = 7;
    localparam int DIGIT_W = 4;
    localparam int STEP_W  = 5;

    localparam logic [AMT_W-1:0] MAX_DIGIT = 16'd9;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GRID_ROWS = 2'd0,
        CFG_GRID_COLS = 2'd1,
        CFG_SEG_LEN   = 2'd2
    } t_cfg_addr;

    typedef enum logic [ACT_W-1:0] {
        ACT_RENDER = 3'd0,
        ACT_UP     = 3'd1,
        ACT_DOWN   = 3'd2,
        ACT_LEFT   = 3'd3,
        ACT_RIGHT  = 3'd4,
        ACT_READ   = 3'd5
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_NOT_DIGIT  = 2'd1,
        STAT_BAD_ACTION = 2'd2,
        STAT_OUT_RANGE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_MOD,
        ST_COL_MOD,
        ST_AMT_MOD,
        ST_FINISH,
        ST_REGION
    } t_state;

    // request into the shared remainder unit
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [AMT_W-1:0]  dividend;  // left-aligned, steps bits are used
    } t_mod_req;

    // segment masks, bit 0 is segment a
    function automatic logic [6:0] seg_mask(input logic [DIGIT_W-1:0] digit);
        logic [6:0] m;
        case (digit)
            4'd0:    m = 7'h3F;
            4'd1:    m = 7'h06;
            4'd2:    m = 7'h5B;
            4'd3:    m = 7'h4F;
            4'd4:    m = 7'h66;
            4'd5:    m = 7'h6D;
            4'd6:    m = 7'h7D;
            4'd7:    m = 7'h07;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

    // len / 3 for 8-bit len, via multiply by 171 and shift by 9
    function automatic logic [THIRD_W-1:0] third(input logic [SEG_W-1:0] len);
        logic [SEG_W+SEG_W-1:0] prod;
        prod = {{SEG_W{1'b0}}, len} * 16'd171;
        return prod[9 +: THIRD_W];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ssrs_mod_unit.sv */
// ============================================================================
// ssrs_mod_unit
// bit-serial restoring remainder unit, one dividend bit per cycle
// ============================================================================
`default_nettype none

module ssrs_mod_unit #(
    parameter int DIV_W = 9
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ssrs_pkg::t_mod_req i_req,
    input  wire logic [DIV_W-1:0]   i_divisor,
    output logic                    o_done,
    output logic [DIV_W-1:0]        o_rem
);

    logic                        r_busy;
    logic                        r_done;
    logic [ssrs_pkg::STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]            r_rem;
    logic [DIV_W-1:0]            r_div;
    logic [ssrs_pkg::AMT_W-1:0]  r_dvd;
    logic [DIV_W:0]              w_trial;
    logic [DIV_W-1:0]            n_rem;

    // shift in next dividend bit, subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[ssrs_pkg::AMT_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = DIV_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - ssrs_pkg::STEP_W'(1);
                if (r_cnt == ssrs_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("remainder unit restarted while busy");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running operation");
`endif

endmodule

`default_nettype wire

/* rtl/core/seven_segment_raster_scroller.sv */
// ============================================================================
// seven_segment_raster_scroller
// seven-segment digit drawn on a scrollable dot grid, read one pixel at a time
// ============================================================================
// usage:
//   requests enter on the s_axis channel (action, amount, row, col); every
//   request gives exactly one response on m_axis (pixel_lit, status).
//   registers grid_rows, grid_cols and segment_length are written through
//   the cfg port while no request is in flight.
// sequencing:
//   one request at a time; s_axis_tready is high only while idle. cost is
//   set by the shared bit-serial remainder unit (one bit per cycle), with
//   OW = clog2(MAX_ROWS or MAX_COLS), 8 at the default sizes:
//     render, invalid action : straight to the response
//     read pixel             : row and col offset mod, OW bits each, then region
//     scroll                 : offset mod over OW bits, amount mod over 16 bits
// reset:
//   synchronous, active low; registers return to 16 x 8 grid, segment
//   length 6, grid dark, offsets zero.
// stall:
//   the response sits in an output register; the next request is already
//   worked on while it waits, and only its final write stalls until the
//   downstream side takes the previous response.
// ============================================================================
`default_nettype none

module seven_segment_raster_scroller #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [ssrs_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [ssrs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // request channel
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // action[2:0], amount[18:3], row[26:19], col[34:27], zero pad
    input  wire logic [ssrs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // response channel
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // pixel_lit[0], status[2:1], zero pad
    output logic [ssrs_pkg::M_TDATA_W-1:0]          m_axis_tdata
);

    // effective size widths (must hold MAX itself), offset widths, datapath
    localparam int RS_W  = $clog2(MAX_ROWS + 1);
    localparam int CS_W  = $clog2(MAX_COLS + 1);
    localparam int RO_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CO_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DW    = (RS_W > CS_W) ? RS_W : CS_W;
    localparam int SW    = DW + 1;
    localparam int CMP_W = ((DW > 10) ? DW : 10) + 2;

    // clamp a size register to 1..max
    function automatic logic [DW-1:0] eff_size(
        input logic [ssrs_pkg::CFG_DATA_W-1:0] v,
        input int                              max
    );
        logic [DW-1:0] r;
        if (v == '0) begin
            r = DW'(1);
        end else if (int'(v) > max) begin
            r = DW'(max);
        end else begin
            r = DW'(v);
        end
        return r;
    endfunction

    // configuration registers
    logic [ssrs_pkg::CFG_DATA_W-1:0] r_grid_rows;
    logic [ssrs_pkg::CFG_DATA_W-1:0] r_grid_cols;
    logic [ssrs_pkg::SEG_W-1:0]      r_seg_len;

    // display state
    logic [ssrs_pkg::DIGIT_W-1:0]    r_digit;
    logic                            r_digit_valid;
    logic [RO_W-1:0]                 r_row_ofs;
    logic [CO_W-1:0]                 r_col_ofs;

    // request in flight
    ssrs_pkg::t_state                r_state, n_state;
    ssrs_pkg::t_action               r_action;
    logic [ssrs_pkg::AMT_W-1:0]      r_amount;
    logic [ssrs_pkg::COORD_W-1:0]    r_row;
    logic [ssrs_pkg::COORD_W-1:0]    r_col;
    logic                            r_oor;
    logic [DW-1:0]                   r_ro;
    logic [DW-1:0]                   r_co;
    logic [DW-1:0]                   r_amod;
    logic [DW-1:0]                   r_si;
    logic [DW-1:0]                   r_sj;

    // response register
    logic                            r_out_valid;
    logic                            r_out_lit;
    ssrs_pkg::t_status               r_out_status;

    // combinational
    logic [DW-1:0]                   w_rows;
    logic [DW-1:0]                   w_cols;
    ssrs_pkg::t_action               w_in_action;
    logic [ssrs_pkg::COORD_W-1:0]    w_in_row;
    logic [ssrs_pkg::COORD_W-1:0]    w_in_col;
    logic                            w_accept;
    ssrs_pkg::t_mod_req              w_req;
    logic [DW-1:0]                   w_divisor;
    logic                            w_mod_done;
    logic [DW-1:0]                   w_mod_rem;
    logic                            w_out_free;
    logic                            w_out_load;
    logic                            w_res_lit;
    ssrs_pkg::t_status               w_res_status;
    logic                            w_row_axis;
    logic [SW-1:0]                   w_scr_base;
    logic [SW-1:0]                   w_scr_size;
    logic [SW-1:0]                   w_scr_sum;
    logic [SW-1:0]                   w_scr_wrap;
    logic [SW-1:0]                   w_si_sum;
    logic [SW-1:0]                   w_sj_sum;
    logic [DW-1:0]                   w_si_wrap;
    logic [DW-1:0]                   w_sj_wrap;
    logic                            w_seg_hit;
    logic [2:0]                      w_seg_idx;
    logic [6:0]                      w_mask;

    assign w_rows      = eff_size(r_grid_rows, MAX_ROWS);
    assign w_cols      = eff_size(r_grid_cols, MAX_COLS);
    assign w_in_action = ssrs_pkg::t_action'(s_axis_tdata[ssrs_pkg::ACT_LSB +: ssrs_pkg::ACT_W]);
    assign w_in_row    = s_axis_tdata[ssrs_pkg::ROW_LSB +: ssrs_pkg::COORD_W];
    assign w_in_col    = s_axis_tdata[ssrs_pkg::COL_LSB +: ssrs_pkg::COORD_W];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= 9'd16;
            r_grid_cols <= 9'd8;
            r_seg_len   <= 8'd6;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ssrs_pkg::CFG_GRID_ROWS: r_grid_rows <= i_cfg_wdata;
                ssrs_pkg::CFG_GRID_COLS: r_grid_cols <= i_cfg_wdata;
                ssrs_pkg::CFG_SEG_LEN:   r_seg_len   <= i_cfg_wdata[ssrs_pkg::SEG_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // shared remainder unit: offset mod size and distance mod size
    // ------------------------------------------------------------------
    ssrs_mod_unit #(
        .DIV_W (DW)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_divisor (w_divisor),
        .o_done    (w_mod_done),
        .o_rem     (w_mod_rem)
    );

    // ------------------------------------------------------------------
    // scroll arithmetic: both operands already below the size, so the
    // sum wraps with a single compare and subtract
    // ------------------------------------------------------------------
    always_comb begin
        w_row_axis = (r_action == ssrs_pkg::ACT_UP) || (r_action == ssrs_pkg::ACT_DOWN);
        w_scr_base = w_row_axis ? SW'(r_ro) : SW'(r_co);
        w_scr_size = w_row_axis ? SW'(w_rows) : SW'(w_cols);
        if ((r_action == ssrs_pkg::ACT_UP) || (r_action == ssrs_pkg::ACT_LEFT)) begin
            w_scr_sum = w_scr_base + SW'(r_amod);
        end else begin
            w_scr_sum = w_scr_base + w_scr_size - SW'(r_amod);
        end
        w_scr_wrap = (w_scr_sum >= w_scr_size) ? (w_scr_sum - w_scr_size) : w_scr_sum;
    end

    // pixel read: map back through the offsets
    always_comb begin
        w_si_sum  = SW'(r_row) + SW'(r_ro);
        w_sj_sum  = SW'(r_col) + SW'(r_co);
        w_si_wrap = (w_si_sum >= SW'(w_rows)) ? DW'(w_si_sum - SW'(w_rows)) : DW'(w_si_sum);
        w_sj_wrap = (w_sj_sum >= SW'(w_cols)) ? DW'(w_sj_sum - SW'(w_cols)) : DW'(w_sj_sum);
    end

    // ------------------------------------------------------------------
    // segment region of the unshifted pixel, first match wins (a..g)
    // ------------------------------------------------------------------
    always_comb begin
        logic [CMP_W-1:0] i_c, j_c, c_c, l_c, w_c;
        logic             mid, right, left, upper, lower, bottom, center;
        i_c    = CMP_W'(r_si);
        j_c    = CMP_W'(r_sj);
        c_c    = CMP_W'(w_cols);
        l_c    = CMP_W'(r_seg_len);
        w_c    = CMP_W'(ssrs_pkg::third(r_seg_len));
        left   = j_c < w_c;
        right  = (j_c + w_c) >= c_c;
        mid    = !left && !right;
        upper  = (i_c >= w_c) && (i_c < w_c + l_c);
        lower  = (i_c >= w_c + w_c + l_c) && (i_c < w_c + w_c + l_c + l_c);
        bottom = i_c >= w_c + w_c + l_c + l_c;
        center = (i_c >= w_c + l_c) && (i_c < w_c + w_c + l_c);
        w_seg_hit = 1'b1;
        if ((i_c < w_c) && mid) begin
            w_seg_idx = 3'd0;
        end else if (upper && right) begin
            w_seg_idx = 3'd1;
        end else if (lower && right) begin
            w_seg_idx = 3'd2;
        end else if (bottom && mid) begin
            w_seg_idx = 3'd3;
        end else if (lower && left) begin
            w_seg_idx = 3'd4;
        end else if (upper && left) begin
            w_seg_idx = 3'd5;
        end else if (center && mid) begin
            w_seg_idx = 3'd6;
        end else begin
            w_seg_idx = 3'd0;
            w_seg_hit = 1'b0;  // background
        end
        w_mask = ssrs_pkg::seg_mask(r_digit);
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssrs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_out_load   = 1'b0;
        w_res_lit    = 1'b0;
        w_res_status = ssrs_pkg::STAT_OK;
        w_req        = '0;
        w_divisor    = w_rows;

        unique case (r_state)
            ssrs_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (w_in_action) inside
                        ssrs_pkg::ACT_UP, ssrs_pkg::ACT_DOWN, ssrs_pkg::ACT_READ:
                            n_state = ssrs_pkg::ST_ROW_MOD;
                        ssrs_pkg::ACT_LEFT, ssrs_pkg::ACT_RIGHT:
                            n_state = ssrs_pkg::ST_COL_MOD;
                        default:
                            n_state = ssrs_pkg::ST_FINISH;
                    endcase
                end
            end
            ssrs_pkg::ST_ROW_MOD: begin
                if (w_mod_done) begin
                    n_state = (r_action == ssrs_pkg::ACT_READ) ? ssrs_pkg::ST_COL_MOD
                                                               : ssrs_pkg::ST_AMT_MOD;
                end
            end
            ssrs_pkg::ST_COL_MOD: begin
                if (w_mod_done) begin
                    n_state = (r_action == ssrs_pkg::ACT_READ) ? ssrs_pkg::ST_FINISH
                                                               : ssrs_pkg::ST_AMT_MOD;
                end
            end
            ssrs_pkg::ST_AMT_MOD: begin
                if (w_mod_done) begin
                    n_state = ssrs_pkg::ST_FINISH;
                end
            end
            ssrs_pkg::ST_FINISH: begin
                if (r_action == ssrs_pkg::ACT_READ) begin
                    n_state = ssrs_pkg::ST_REGION;
                end else if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = ssrs_pkg::ST_IDLE;
                    case (r_action) inside
                        ssrs_pkg::ACT_RENDER:
                            w_res_status = (r_amount > ssrs_pkg::MAX_DIGIT)
                                         ? ssrs_pkg::STAT_NOT_DIGIT : ssrs_pkg::STAT_OK;
                        ssrs_pkg::ACT_UP, ssrs_pkg::ACT_DOWN,
                        ssrs_pkg::ACT_LEFT, ssrs_pkg::ACT_RIGHT:
                            w_res_status = ssrs_pkg::STAT_OK;
                        default:
                            w_res_status = ssrs_pkg::STAT_BAD_ACTION;
                    endcase
                end
            end
            ssrs_pkg::ST_REGION: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    n_state      = ssrs_pkg::ST_IDLE;
                    w_res_status = r_oor ? ssrs_pkg::STAT_OUT_RANGE : ssrs_pkg::STAT_OK;
                    w_res_lit    = !r_oor && r_digit_valid && w_seg_hit && w_mask[w_seg_idx];
                end
            end
            default: n_state = ssrs_pkg::ST_IDLE;
        endcase

        // launch the remainder unit on entry to a mod state
        if (n_state != r_state) begin
            unique case (n_state)
                ssrs_pkg::ST_ROW_MOD: begin
                    w_req.start    = 1'b1;
                    w_req.steps    = ssrs_pkg::STEP_W'(RO_W);
                    w_req.dividend = ssrs_pkg::AMT_W'(r_row_ofs) << (ssrs_pkg::AMT_W - RO_W);
                    w_divisor      = w_rows;
                end
                ssrs_pkg::ST_COL_MOD: begin
                    w_req.start    = 1'b1;
                    w_req.steps    = ssrs_pkg::STEP_W'(CO_W);
                    w_req.dividend = ssrs_pkg::AMT_W'(r_col_ofs) << (ssrs_pkg::AMT_W - CO_W);
                    w_divisor      = w_cols;
                end
                ssrs_pkg::ST_AMT_MOD: begin
                    w_req.start    = 1'b1;
                    w_req.steps    = ssrs_pkg::STEP_W'(ssrs_pkg::AMT_W);
                    w_req.dividend = r_amount;
                    w_divisor      = w_row_axis ? w_rows : w_cols;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request payload and working registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= w_in_action;
            r_amount <= s_axis_tdata[ssrs_pkg::AMT_LSB +: ssrs_pkg::AMT_W];
            r_row    <= w_in_row;
            r_col    <= w_in_col;
            r_oor    <= (int'(w_in_row) >= int'(w_rows)) || (int'(w_in_col) >= int'(w_cols));
        end
        if (w_mod_done) begin
            unique case (r_state)
                ssrs_pkg::ST_ROW_MOD: r_ro   <= w_mod_rem;
                ssrs_pkg::ST_COL_MOD: r_co   <= w_mod_rem;
                ssrs_pkg::ST_AMT_MOD: r_amod <= w_mod_rem;
                default: ;
            endcase
        end
        if (r_state == ssrs_pkg::ST_FINISH) begin
            r_si <= w_si_wrap;
            r_sj <= w_sj_wrap;
        end
    end

    // ------------------------------------------------------------------
    // display state, committed together with the response
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit       <= '0;
            r_digit_valid <= 1'b0;
            r_row_ofs     <= '0;
            r_col_ofs     <= '0;
        end else if (w_out_load && (r_state == ssrs_pkg::ST_FINISH)) begin
            case (r_action) inside
                ssrs_pkg::ACT_RENDER: begin
                    if (r_amount <= ssrs_pkg::MAX_DIGIT) begin
                        r_digit       <= r_amount[ssrs_pkg::DIGIT_W-1:0];
                        r_digit_valid <= 1'b1;
                        r_row_ofs     <= '0;
                        r_col_ofs     <= '0;
                    end
                end
                ssrs_pkg::ACT_UP, ssrs_pkg::ACT_DOWN:
                    r_row_ofs <= w_scr_wrap[RO_W-1:0];
                ssrs_pkg::ACT_LEFT, ssrs_pkg::ACT_RIGHT:
                    r_col_ofs <= w_scr_wrap[CO_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // response register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_lit    <= w_res_lit;
            r_out_status <= w_res_status;
        end
    end

    assign s_axis_tready = (r_state == ssrs_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ssrs_pkg::M_TDATA_W - ssrs_pkg::STAT_W - 1){1'b0}},
                            r_out_status, r_out_lit};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("request taken while previous one still in work");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_valid |-> (r_digit <= ssrs_pkg::DIGIT_W'(9)))
        else $error("stored digit out of range");

    a_lit_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_lit) |-> (r_out_status == ssrs_pkg::STAT_OK) && r_digit_valid)
        else $error("lit pixel with error status or dark grid");

    a_ofs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_row_ofs) < MAX_ROWS) && (int'(r_col_ofs) < MAX_COLS))
        else $error("scroll offset beyond grid maximum");

    a_done_in_mod_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == ssrs_pkg::ST_ROW_MOD) || (r_state == ssrs_pkg::ST_COL_MOD)
                       || (r_state == ssrs_pkg::ST_AMT_MOD))
        else $error("remainder result arrived outside a mod state");
`endif

endmodule

`default_nettype wire

/* tb/tb_seven_segment_raster_scroller.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_seven_segment_raster_scroller
// self-checking bench for the seven-segment raster scroller
// ============================================================================
// requests (render, scrolls, pixel reads, invalid actions) go in on s_axis
// and every response on m_axis is checked against a pixel predictor kept in
// a small scoreboard. the run moves through several grid settings, extremes
// included, with random idling on both stream sides.
// ============================================================================

module tb_seven_segment_raster_scroller;

    localparam int TB_MAX_ROWS = 256;
    localparam int TB_MAX_COLS = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 67;

    // action codes with no meaning, answered with an invalid-action status
    localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
    localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

    // ------------------------------------------------------------------------
    // scoreboard: glyph predictor plus queue of expected responses
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        typedef struct {
            logic              lit;
            ssrs_pkg::t_status status;
        } t_pixel_result;

        t_pixel_result expected_q[$];
        int          errors;
        int          max_rows;
        int          max_cols;
        logic [8:0]  grid_rows;
        logic [8:0]  grid_cols;
        logic [7:0]  seg_len;
        logic [3:0]  digit;
        bit          grid_lit;
        int          row_off;
        int          col_off;
        bit [6:0]    glyph_bits [10];

        function new(int mr, int mc);
            max_rows   = mr;
            max_cols   = mc;
            errors     = 0;
            grid_rows  = 9'd16;
            grid_cols  = 9'd8;
            seg_len    = 8'd6;
            digit      = '0;
            grid_lit   = 1'b0;
            row_off    = 0;
            col_off    = 0;
            // bit 0 is the top bar, bit 6 the middle bar
            glyph_bits = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                           7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
        endfunction

        function void set_reg(ssrs_pkg::t_cfg_addr a, logic [8:0] v);
            case (a)
                ssrs_pkg::CFG_GRID_ROWS: grid_rows = v;
                ssrs_pkg::CFG_GRID_COLS: grid_cols = v;
                ssrs_pkg::CFG_SEG_LEN:   seg_len   = v[7:0];
                default: ;
            endcase
        endfunction

        // zero counts as one, oversize clips to the maximum
        function int clip_size(int v, int m);
            if (v == 0) return 1;
            if (v > m) return m;
            return v;
        endfunction

        function int rows_n();
            return clip_size(int'(grid_rows), max_rows);
        endfunction

        function int cols_n();
            return clip_size(int'(grid_cols), max_cols);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // segment index 0..6 for an unshifted pixel, -1 for background
        function int segment_at(int i, int j, int ncols, int len);
            int w;
            bit mid, right, left, upper, lower;
            w     = len / 3;
            mid   = (j >= w) && (j < ncols - w);
            right = (j >= ncols - w);
            left  = (j < w);
            upper = (i >= w) && (i < w + len);
            lower = (i >= 2 * w + len) && (i < 2 * w + 2 * len);
            if (i < w && mid) return 0;
            if (upper && right) return 1;
            if (lower && right) return 2;
            if (i >= 2 * w + 2 * len && mid) return 3;
            if (lower && left) return 4;
            if (upper && left) return 5;
            if (i >= w + len && i < 2 * w + len && mid) return 6;
            return -1;
        endfunction

        function void note_request(logic [2:0] act, logic [15:0] amt,
                                   logic [7:0] r, logic [7:0] c);
            int rows, cols, ro, co, a, seg;
            t_pixel_result e;
            rows     = rows_n();
            cols     = cols_n();
            ro       = row_off % rows;
            co       = col_off % cols;
            a        = int'(amt);
            seg      = -1;
            e.lit    = 1'b0;
            e.status = ssrs_pkg::STAT_OK;
            case (act)
                ssrs_pkg::ACT_RENDER: begin
                    if (amt > ssrs_pkg::MAX_DIGIT) begin
                        e.status = ssrs_pkg::STAT_NOT_DIGIT;
                    end else begin
                        digit    = amt[3:0];
                        grid_lit = 1'b1;
                        row_off  = 0;
                        col_off  = 0;
                    end
                end
                ssrs_pkg::ACT_UP:    row_off = (ro + a % rows) % rows;
                ssrs_pkg::ACT_DOWN:  row_off = (ro + rows - a % rows) % rows;
                ssrs_pkg::ACT_LEFT:  col_off = (co + a % cols) % cols;
                ssrs_pkg::ACT_RIGHT: col_off = (co + cols - a % cols) % cols;
                ssrs_pkg::ACT_READ: begin
                    if (int'(r) >= rows || int'(c) >= cols) begin
                        e.status = ssrs_pkg::STAT_OUT_RANGE;
                    end else if (grid_lit) begin
                        // map back through the scroll offsets
                        seg = segment_at((int'(r) + ro) % rows, (int'(c) + co) % cols,
                                         cols, int'(seg_len));
                        if (seg >= 0) e.lit = glyph_bits[digit][seg];
                    end
                end
                default: e.status = ssrs_pkg::STAT_BAD_ACTION;
            endcase
            expected_q.push_back(e);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_response(logic [ssrs_pkg::M_TDATA_W-1:0] d);
            t_pixel_result e;
            if (expected_q.size() == 0) begin
                report($sformatf("response %h with no request pending", d));
                return;
            end
            e = expected_q.pop_front();
            if (d[0] !== e.lit)
                report($sformatf("pixel_lit got %b want %b", d[0], e.lit));
            if (d[2:1] !== e.status)
                report($sformatf("status got %0d want %0d", d[2:1], e.status));
            if (d[ssrs_pkg::M_TDATA_W-1:3] !== '0)
                report($sformatf("pad bits not zero: %h", d));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [ssrs_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [ssrs_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ssrs_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ssrs_pkg::M_TDATA_W-1:0]  m_axis_tdata;

    // idle chances in percent, changed per phase
    int send_idle_pct = 9;
    int recv_idle_pct = 67;
    int cycle_count   = 0;

    pixel_scoreboard sb = new(TB_MAX_ROWS, TB_MAX_COLS);

    always #5 i_clk = ~i_clk;

    seven_segment_raster_scroller #(
        .MAX_ROWS(TB_MAX_ROWS),
        .MAX_COLS(TB_MAX_COLS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // action[2:0], amount[18:3], row[26:19], col[34:27], zero pad
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // pixel_lit[0], status[2:1], zero pad
        .m_axis_tdata (m_axis_tdata)
    );

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // response side: values read here are the ones present at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_response(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------------

    // one request; valid stays high into the next one unless a gap is drawn
    task automatic send_request(input logic [2:0] act, input logic [15:0] amt,
                                input logic [7:0] r, input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(ssrs_pkg::S_TDATA_W - 35){1'b0}}, c, r, amt, act};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(act, amt, r, c);
    endtask

    // drop valid and wait until every response is back
    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input ssrs_pkg::t_cfg_addr a, input logic [8:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= a;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_reg(a, v);
    endtask

    task automatic apply_setting(input logic [8:0] rows, input logic [8:0] cols,
                                 input logic [7:0] len);
        write_reg(ssrs_pkg::CFG_GRID_ROWS, rows);
        write_reg(ssrs_pkg::CFG_GRID_COLS, cols);
        write_reg(ssrs_pkg::CFG_SEG_LEN, {1'b0, len});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random request, mostly reads inside the grid with scrolls and renders
    task automatic send_random_request();
        int p, rows, cols;
        logic [2:0]  act;
        logic [15:0] amt;
        logic [7:0]  r, c;
        rows = sb.rows_n();
        cols = sb.cols_n();
        p    = $urandom_range(0, 99);
        amt  = 16'($urandom_range(0, 65535));
        r    = 8'($urandom_range(0, 255));
        c    = 8'($urandom_range(0, 255));
        if (p < 15) begin
            act = ssrs_pkg::ACT_RENDER;
            if ($urandom_range(0, 99) < 80) amt = 16'($urandom_range(0, 9));
        end else if (p < 45) begin
            act = 3'($urandom_range(ssrs_pkg::ACT_UP, ssrs_pkg::ACT_RIGHT));
            if ($urandom_range(0, 1) == 0) amt = 16'($urandom_range(0, 600));
        end else if (p < 93) begin
            act = ssrs_pkg::ACT_READ;
            if ($urandom_range(0, 99) < 85) begin
                r = 8'($urandom_range(0, rows - 1));
                c = 8'($urandom_range(0, cols - 1));
            end
        end else begin
            // undefined actions above read
            act = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
        end
        send_request(act, amt, r, c);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [8:0] set_rows [NUM_PHASES];
        logic [8:0] set_cols [NUM_PHASES];
        logic [7:0] set_len  [NUM_PHASES];
        // grid settings per phase: normal, max, zero, oversize, thin, mid
        set_rows = '{9'd24,  9'd256, 9'd0, 9'd511, 9'd1,   9'd40};
        set_cols = '{9'd13,  9'd256, 9'd0, 9'd300, 9'd256, 9'd20};
        set_len  = '{8'd6,   8'd255, 8'd0, 8'd9,   8'd3,   8'd10};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on the reset grid (16 x 8, segment length 6)
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd3, 8'd3);       // dark grid
        send_request(ssrs_pkg::ACT_UP, 16'd5, 8'd0, 8'd0);         // scroll before render
        send_request(ssrs_pkg::ACT_RENDER, 16'd12, 8'd0, 8'd0);    // not a digit
        send_request(ssrs_pkg::ACT_RENDER, 16'hFFFF, 8'd0, 8'd0);
        send_request(ACT_UNDEF_LO, 16'd0, 8'd0, 8'd0);             // undefined actions
        send_request(ACT_UNDEF_HI, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd0, 8'd0);       // still dark
        send_request(ssrs_pkg::ACT_RENDER, 16'd8, 8'd0, 8'd0);     // clears offsets
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd0, 8'd3);       // top bar
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd4, 8'd7);       // upper right
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd9, 8'd4);       // middle bar
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd15, 8'd0);      // lower left
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd16, 8'd0);      // row out of range
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd0, 8'd8);       // col out of range
        send_request(ssrs_pkg::ACT_READ, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(ssrs_pkg::ACT_UP, 16'hFFFF, 8'd0, 8'd0);
        send_request(ssrs_pkg::ACT_DOWN, 16'd1, 8'd0, 8'd0);
        send_request(ssrs_pkg::ACT_LEFT, 16'd0, 8'd0, 8'd0);
        send_request(ssrs_pkg::ACT_RIGHT, 16'hFFFF, 8'd0, 8'd0);
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd5, 8'd5);
        send_request(ssrs_pkg::ACT_RENDER, 16'd1, 8'd0, 8'd0);
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd12, 8'd7);
        send_request(ssrs_pkg::ACT_RENDER, 16'd0, 8'd0, 8'd0);
        send_request(ssrs_pkg::ACT_READ, 16'd0, 8'd9, 8'd4);       // middle bar off for zero
        send_request(ssrs_pkg::ACT_RENDER, 16'd9, 8'd0, 8'd0);
        drain_requests();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // sender idles lightly first, then the receiver, then neither
            if (ph < 2) begin
                send_idle_pct = 9;
                recv_idle_pct = 67;
            end else if (ph < 4) begin
                send_idle_pct = 67;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(set_rows[ph], set_cols[ph], set_len[ph]);
            // start each phase with a glyph on screen
            send_request(ssrs_pkg::ACT_RENDER, 16'($urandom_range(0, 9)), 8'd0, 8'd0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_request();
            drain_requests();
        end

        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
